[src/itcc_pkg.sv]
// shared types, constants and the end-around-carry add for the checksum core
// no dependencies; imported by every module of the block
package itcc_pkg;

    // checksum mode codes
    localparam logic MODE_IP  = 1'b0;
    localparam logic MODE_TCP = 1'b1;

    // protocol and layout constants
    localparam logic [15:0] PROTO_TCP       = 16'h0006;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [15:0] IP_CSUM_POS     = 16'd5;
    localparam logic [5:0]  TCP_CSUM_OFFSET = 6'd8;
    localparam logic [15:0] PSEUDO_FIRST    = 16'd6;
    localparam logic [15:0] PSEUDO_LAST     = 16'd9;
    localparam logic [15:0] POS_MAX         = 16'hffff;
    localparam logic [15:0] HIGH_BYTE_MASK  = 16'hff00;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // input beat
    typedef struct packed {
        logic [15:0] data_word;
        logic        end_of_packet;
    } in_t;

    // result beat
    typedef struct packed {
        logic [15:0] checksum;
        logic        length_error;
    } out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [15:0] word;   // already masked, zero when not summed
        logic        last;
        logic        err;
        logic [15:0] extra;  // pseudo-header tail term, zero in ip mode
    } entry_t;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] add_eac(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

[src/itcc_front.sv]
// front end: tracks packet position and lengths, classifies each word
// depends on itcc_pkg
module itcc_front
    import itcc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   mode,
    input  in_t    word,
    input  logic   accept,
    output entry_t entry
);

    logic [15:0] pos_reg, pos_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] tot_reg, tot_next;
    logic        bad_reg, bad_next;

    logic [3:0]  ihl_cur;
    logic [15:0] tot_cur;
    logic        bad_cur;
    logic [4:0]  hw;
    logic [5:0]  hb;
    logic [15:0] sl;
    logic [15:0] diff;
    logic [16:0] off_p1;
    logic [16:0] need;
    logic [16:0] pos_p1;
    logic [15:0] w;
    logic        pseudo_hit;
    logic        seg_hit;
    logic [15:0] word_sel;

    assign w = word.data_word;

    // lengths as seen by this word
    always_comb
    begin
        ihl_cur = (pos_reg == 16'd0) ? w[11:8] : ihl_reg;
        tot_cur = (pos_reg == 16'd1) ? w : tot_reg;
        bad_cur = bad_reg
                | ((pos_reg == 16'd0) && (w[11:8] < IHL_MIN))
                | ((pos_reg == 16'd1) && (w < {10'b0, ihl_reg, 2'b0}));
        hw      = {ihl_cur, 1'b0};
        hb      = {ihl_cur, 2'b0};
        sl      = (tot_cur >= {10'b0, hb}) ? (tot_cur - {10'b0, hb}) : 16'd0;
        diff    = pos_reg - {11'b0, hw};
        off_p1  = {diff, 1'b1};
        need    = {12'b0, hw} + ((mode == MODE_TCP) ? ((({1'b0, sl} + 17'd1) >> 1)) : 17'd0);
        pos_p1  = {1'b0, pos_reg} + 17'd1;
    end

    // word classification
    always_comb
    begin
        pseudo_hit = (pos_reg >= PSEUDO_FIRST) && (pos_reg <= PSEUDO_LAST);
        seg_hit    = (pos_reg >= 16'd2) && (pos_reg >= {11'b0, hw})
                   && (pos_reg != {10'b0, ({1'b0, hw} + TCP_CSUM_OFFSET)});
        word_sel   = 16'd0;
        if (mode == MODE_IP)
        begin
            if ((pos_reg < {11'b0, hw}) && (pos_reg != IP_CSUM_POS))
                word_sel = w;
        end
        else
        begin
            // both hits only happen with ihl below minimum, which flags an error
            if (pseudo_hit)
                word_sel = w;
            else if (seg_hit && (off_p1 < {1'b0, sl}))
                word_sel = w;
            else if (seg_hit && (off_p1 == {1'b0, sl}))
                word_sel = w & HIGH_BYTE_MASK;
        end
    end

    // entry for the queue
    always_comb
    begin
        entry.word  = word_sel;
        entry.last  = word.end_of_packet;
        entry.err   = bad_cur | (pos_p1 < need);
        entry.extra = (mode == MODE_TCP) ? add_eac(PROTO_TCP, sl) : 16'd0;
    end

    // packet state update
    always_comb
    begin
        pos_next = pos_reg;
        ihl_next = ihl_reg;
        tot_next = tot_reg;
        bad_next = bad_reg;
        if (accept)
        begin
            if (word.end_of_packet)
            begin
                pos_next = 16'd0;
                ihl_next = 4'd0;
                tot_next = 16'd0;
                bad_next = 1'b0;
            end
            else
            begin
                pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_p1[15:0];
                ihl_next = ihl_cur;
                tot_next = tot_cur;
                bad_next = bad_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 16'd0;
            ihl_reg <= 4'd0;
            tot_reg <= 16'd0;
            bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            ihl_reg <= ihl_next;
            tot_reg <= tot_next;
            bad_reg <= bad_next;
        end
    end

endmodule

[src/itcc_fifo.sv]
// short queue of classified words between front and back
// depends on itcc_pkg
module itcc_fifo
    import itcc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   not_full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = queue_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= push_data;
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // a lone push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

[src/itcc_back.sv]
// back end: end-around-carry accumulator and result register
// depends on itcc_pkg
module itcc_back
    import itcc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   entry_valid,
    input  entry_t entry,
    output logic   pop,
    output out_t   result,
    output logic   result_valid,
    input  logic   result_ready
);

    logic [15:0] sum_reg, sum_next;
    out_t        result_reg, result_next;
    logic        result_valid_reg, result_valid_next;
    logic        can_take;
    logic [15:0] sum_word;
    logic [15:0] sum_final;

    // a last word needs the result register free
    assign can_take = !entry.last || !result_valid_reg || result_ready;
    assign pop      = entry_valid && can_take;

    assign sum_word  = add_eac(sum_reg, entry.word);
    assign sum_final = add_eac(sum_word, entry.extra);

    // accumulate and close out packets
    always_comb
    begin
        sum_next          = sum_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (pop)
        begin
            if (entry.last)
            begin
                sum_next                 = 16'd0;
                result_next.checksum     = entry.err ? 16'd0 : ~sum_final;
                result_next.length_error = entry.err;
                result_valid_next        = 1'b1;
            end
            else
            begin
                sum_next = sum_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= 16'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // a flagged packet carries a zero checksum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.length_error) |-> (result_reg.checksum == 16'd0))
        else $error("length error with nonzero checksum");

    // a new result only follows a popped last word
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(pop && entry.last))
        else $error("result without a last word");

endmodule

[src/ipv4_tcp_ones_complement_checksum_core.sv]
// top level of the ipv4 / tcp ones' complement checksum core
// depends on itcc_pkg, itcc_front, itcc_fifo, itcc_back
//
// Usage:
// - word channel (word_valid / word_ready / word): packet as big-endian
//   16-bit words, end_of_packet set on the final beat.
// - result channel (result_valid / result_ready / result): one beat per
//   packet, on its final word: checksum (bits 15:8 first on wire) and
//   length_error; a flagged packet gives checksum zero.
// - cfg_write / cfg_data set checksum_mode (0 ip header, 1 tcp with
//   pseudo-header); the user must write it only while the core is idle, which the core does not enforce.
// - throughput: one word per cycle while word_ready is high; the front classifies
//   a word in the cycle it is taken, the back adds it to the sum after the queue.
// - result: the last word passes the queue and then the result register,
//   and waits while an earlier result is still in the result register.
// - stall: while result_ready is low the result register holds, the back
//   keeps summing non-final words, and word_ready drops once the
//   QUEUE_DEPTH-entry queue fills.
// - reset clears packet state, the queue, the sum and checksum_mode.
module ipv4_tcp_ones_complement_checksum_core
    import itcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    input  logic word_valid,
    output logic word_ready,
    input  in_t  word,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    logic   mode_reg, mode_next;
    logic   accept;
    entry_t front_entry;
    entry_t queue_entry;
    logic   queue_not_full;
    logic   queue_not_empty;
    logic   queue_pop;

    // mode register
    assign mode_next = cfg_write ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IP;
        else
            mode_reg <= mode_next;
    end

    assign word_ready = queue_not_full;
    assign accept     = word_valid && word_ready;

    // front: position tracking and classification
    itcc_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .mode  (mode_reg),
        .word  (word),
        .accept(accept),
        .entry (front_entry)
    );

    // queue between front and back
    itcc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_data(front_entry),
        .not_full (queue_not_full),
        .pop      (queue_pop),
        .not_empty(queue_not_empty),
        .pop_data (queue_entry)
    );

    // back: sum and result
    itcc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_not_empty),
        .entry       (queue_entry),
        .pop         (queue_pop),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

endmodule
